### design/circle_overlap_push_out_core_macros.svh
// ----------------------------------------------------------------------------
// Circle overlap push-out: assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_OVERLAP_PUSH_OUT_CORE_MACROS_SVH
`define CIRCLE_OVERLAP_PUSH_OUT_CORE_MACROS_SVH

// Checked only while out of reset.
`define COP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define COP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### design/cop_pkg.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out: package
// Shared widths, register indexes, pipeline side-band types and helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cop_pkg;

    localparam int COP_FRAC_BITS = 16;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 31;

    localparam logic [16:0] GAIN_ONE = 17'h10000;

    localparam logic REG_MAX_PUSH       = 1'b0;
    localparam logic REG_SMOOTHING_GAIN = 1'b1;

    typedef struct packed {
        logic [31:0] self_x;
        logic [31:0] self_z;
        logic        dx_neg;
        logic        dz_neg;
        logic [31:0] adx;
        logic [31:0] adz;
        logic [31:0] min_dist;
    } cop_geo_t;

    typedef struct packed {
        logic [31:0] self_x;
        logic [31:0] self_z;
        logic        dx_neg;
        logic        dz_neg;
        logic        hit;
        logic        near;
        logic [30:0] push;
    } cop_push_t;

    function automatic logic [31:0] sat32(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### design/cop_sqrt.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out: pipelined square root
// Floor square root of a 64-bit value, one result bit per register stage,
// with the geometry side-band carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cop_sqrt
    import cop_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] in_value,
    input  cop_geo_t    in_side,
    output logic        out_valid,
    output logic [31:0] out_root,
    output cop_geo_t    out_side
);

    logic        vld_reg  [SQRT_STAGES];
    logic [63:0] x_reg    [SQRT_STAGES];
    logic [32:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];
    cop_geo_t    side_reg [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
            logic        vld_prev;
            logic [63:0] x_prev;
            logic [32:0] rem_prev;
            logic [31:0] root_prev;
            cop_geo_t    side_prev;
            logic [34:0] rem_shift;
            logic [34:0] trial;
            logic        take;

            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign x_prev    = in_value;
                assign rem_prev  = '0;
                assign root_prev = '0;
                assign side_prev = in_side;
            end else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign x_prev    = x_reg[k-1];
                assign rem_prev  = rem_reg[k-1];
                assign root_prev = root_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            assign rem_shift = {rem_prev, x_prev[63:62]};
            assign trial     = {1'b0, root_prev, 2'b01};
            assign take      = (rem_shift >= trial);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[k]    <= {x_prev[61:0], 2'b00};
                    rem_reg[k]  <= take ? 33'(rem_shift - trial) : rem_shift[32:0];
                    root_reg[k] <= {root_prev[30:0], take};
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

### design/cop_div.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out: pipelined dual divider
// Two restoring divisions by a shared divisor, one quotient bit per register
// stage. The quotients are known to fit in 31 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cop_div
    import cop_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [62:0] in_num_x,
    input  logic [62:0] in_num_z,
    input  logic [31:0] in_den,
    input  cop_push_t   in_side,
    output logic        out_valid,
    output logic [30:0] out_quo_x,
    output logic [30:0] out_quo_z,
    output cop_push_t   out_side
);

    logic        vld_reg  [DIV_STAGES];
    logic [31:0] den_reg  [DIV_STAGES];
    logic [31:0] remx_reg [DIV_STAGES];
    logic [31:0] remz_reg [DIV_STAGES];
    logic [30:0] lowx_reg [DIV_STAGES];
    logic [30:0] lowz_reg [DIV_STAGES];
    logic [30:0] qx_reg   [DIV_STAGES];
    logic [30:0] qz_reg   [DIV_STAGES];
    cop_push_t   side_reg [DIV_STAGES];

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++) begin : g_stage
            logic        vld_prev;
            logic [31:0] den_prev;
            logic [31:0] remx_prev;
            logic [31:0] remz_prev;
            logic [30:0] lowx_prev;
            logic [30:0] lowz_prev;
            logic [30:0] qx_prev;
            logic [30:0] qz_prev;
            cop_push_t   side_prev;
            logic [32:0] tx;
            logic [32:0] tz;
            logic        gex;
            logic        gez;

            if (k == 0) begin : g_first
                assign vld_prev  = in_valid;
                assign den_prev  = in_den;
                assign remx_prev = in_num_x[62:31];
                assign remz_prev = in_num_z[62:31];
                assign lowx_prev = in_num_x[30:0];
                assign lowz_prev = in_num_z[30:0];
                assign qx_prev   = '0;
                assign qz_prev   = '0;
                assign side_prev = in_side;
            end else begin : g_next
                assign vld_prev  = vld_reg[k-1];
                assign den_prev  = den_reg[k-1];
                assign remx_prev = remx_reg[k-1];
                assign remz_prev = remz_reg[k-1];
                assign lowx_prev = lowx_reg[k-1];
                assign lowz_prev = lowz_reg[k-1];
                assign qx_prev   = qx_reg[k-1];
                assign qz_prev   = qz_reg[k-1];
                assign side_prev = side_reg[k-1];
            end

            assign tx  = {remx_prev, lowx_prev[30]};
            assign tz  = {remz_prev, lowz_prev[30]};
            assign gex = (tx >= {1'b0, den_prev});
            assign gez = (tz >= {1'b0, den_prev});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= vld_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    den_reg[k]  <= den_prev;
                    remx_reg[k] <= gex ? 32'(tx - {1'b0, den_prev}) : tx[31:0];
                    remz_reg[k] <= gez ? 32'(tz - {1'b0, den_prev}) : tz[31:0];
                    lowx_reg[k] <= {lowx_prev[29:0], 1'b0};
                    lowz_reg[k] <= {lowz_prev[29:0], 1'b0};
                    qx_reg[k]   <= {qx_prev[29:0], gex};
                    qz_reg[k]   <= {qz_prev[29:0], gez};
                    side_reg[k] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quo_x = qx_reg[DIV_STAGES-1];
    assign out_quo_z = qz_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

### design/circle_overlap_push_out_core.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out core
// Pushes one body out of another body's circle on the X/Z plane.
// ----------------------------------------------------------------------------
// The core accepts one body pair per clock and presents one result per pair, in
// order. The pipeline is built around the 32-stage square root of the squared
// distance and the 31-stage dividers that split the push into X and Z; the
// whole pipeline holds while a result waits on the output. Configuration
// writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps

module circle_overlap_push_out_core
    import cop_pkg::*;
#(
    parameter int FRAC_BITS = COP_FRAC_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // self_x, self_z, other_x, other_z, self_radius, other_radius, zero pad
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_x, new_z
    output logic [63:0]  m_tdata,
    // pushed
    output logic         m_tuser
);

    localparam logic [31:0] EPS_Q = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    logic        en;
    logic [30:0] max_push_reg;
    logic [16:0] gain_reg;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_push_reg <= 31'd65536;
            gain_reg     <= GAIN_ONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MAX_PUSH:       max_push_reg <= cfg_wdata;
                REG_SMOOTHING_GAIN: gain_reg     <= cfg_wdata[16:0];
                default:            ;
            endcase
        end
    end

    // Stage 1: saturated differences and radius sum.
    logic [31:0] in_sx, in_sz, in_ox, in_oz;
    logic [32:0] dx_next, dz_next;
    logic [31:0] dxs_next, dzs_next;
    cop_geo_t    geo1_next;
    logic        vld1_reg;
    cop_geo_t    geo1_reg;

    assign in_sx    = s_tdata[31:0];
    assign in_sz    = s_tdata[63:32];
    assign in_ox    = s_tdata[95:64];
    assign in_oz    = s_tdata[127:96];
    assign dx_next  = {in_sx[31], in_sx} - {in_ox[31], in_ox};
    assign dz_next  = {in_sz[31], in_sz} - {in_oz[31], in_oz};
    assign dxs_next = sat32(dx_next);
    assign dzs_next = sat32(dz_next);

    always_comb begin
        geo1_next.self_x   = in_sx;
        geo1_next.self_z   = in_sz;
        geo1_next.dx_neg   = dxs_next[31];
        geo1_next.dz_neg   = dzs_next[31];
        geo1_next.adx      = dxs_next[31] ? 32'(-dxs_next) : dxs_next;
        geo1_next.adz      = dzs_next[31] ? 32'(-dzs_next) : dzs_next;
        geo1_next.min_dist = {1'b0, s_tdata[158:128]} + {1'b0, s_tdata[189:159]};
    end

    // Stage 2: squares. Stage 3: sum of squares.
    logic        vld2_reg, vld3_reg;
    cop_geo_t    geo2_reg, geo3_reg;
    logic [63:0] sqx2_reg, sqz2_reg, sum3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo1_reg <= geo1_next;
            geo2_reg <= geo1_reg;
            sqx2_reg <= geo1_reg.adx * geo1_reg.adx;
            sqz2_reg <= geo1_reg.adz * geo1_reg.adz;
            geo3_reg <= geo2_reg;
            sum3_reg <= sqx2_reg + sqz2_reg;
        end
    end

    logic        vlds;
    logic [31:0] dists;
    cop_geo_t    geos;

    cop_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld3_reg),
        .in_value  (sum3_reg),
        .in_side   (geo3_reg),
        .out_valid (vlds),
        .out_root  (dists),
        .out_side  (geos)
    );

    // Stage 4: overlap and clamp. Stage 5: gain. Stage 6: direction products.
    logic        vld4_reg, vld5_reg, vld6_reg;
    cop_geo_t    geo4_reg, geo5_reg;
    logic [31:0] dist4_reg, dist5_reg, dist6_reg;
    logic        hit4_reg, hit5_reg;
    logic [30:0] ovc4_reg, push5_reg;
    logic [16:0] gain_eff;
    logic [47:0] gain_prod;
    logic [62:0] numx6_reg, numz6_reg;
    cop_push_t   side6_reg;

    assign gain_eff  = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;
    assign gain_prod = ovc4_reg * gain_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else if (en) begin
            vld4_reg <= vlds;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geo4_reg  <= geos;
            dist4_reg <= dists;
            hit4_reg  <= (dists < geos.min_dist);
            ovc4_reg  <= (32'(geos.min_dist - dists) > {1'b0, max_push_reg})
                         ? max_push_reg : 31'(geos.min_dist - dists);
            geo5_reg  <= geo4_reg;
            dist5_reg <= dist4_reg;
            hit5_reg  <= hit4_reg;
            push5_reg <= gain_prod[46:16];
            dist6_reg <= dist5_reg;
            numx6_reg <= push5_reg * geo5_reg.adx;
            numz6_reg <= push5_reg * geo5_reg.adz;
            side6_reg <= '{self_x: geo5_reg.self_x, self_z: geo5_reg.self_z,
                           dx_neg: geo5_reg.dx_neg, dz_neg: geo5_reg.dz_neg,
                           hit: hit5_reg, near: (dist5_reg <= EPS_Q),
                           push: push5_reg};
        end
    end

    logic        vldd;
    logic [30:0] quo_x, quo_z;
    cop_push_t   sided;

    cop_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld6_reg),
        .in_num_x  (numx6_reg),
        .in_num_z  (numz6_reg),
        .in_den    (dist6_reg),
        .in_side   (side6_reg),
        .out_valid (vldd),
        .out_quo_x (quo_x),
        .out_quo_z (quo_z),
        .out_side  (sided)
    );

    // Output stage: signed offset and saturated update.
    logic [32:0] offx_next, offz_next;
    logic [32:0] sumx_next, sumz_next;
    logic        m_tvalid_reg, m_tuser_reg;
    logic [63:0] m_tdata_reg;

    always_comb begin
        offx_next = '0;
        offz_next = '0;
        if (sided.hit) begin
            if (sided.near) begin
                offx_next = {2'b00, sided.push};
            end else begin
                offx_next = sided.dx_neg ? 33'(-{2'b00, quo_x}) : {2'b00, quo_x};
                offz_next = sided.dz_neg ? 33'(-{2'b00, quo_z}) : {2'b00, quo_z};
            end
        end
        sumx_next = {sided.self_x[31], sided.self_x} + offx_next;
        sumz_next = {sided.self_z[31], sided.self_z} + offz_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= vldd;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {sat32(sumz_next), sat32(sumx_next)};
            m_tuser_reg <= sided.hit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/cop_checker.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out: port checker
// Checks flow control and the empty output after reset; binds to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_overlap_push_out_core_macros.svh"

module cop_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);

    `COP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `COP_ASSERT(a_ready_follows_out, s_tready == (!m_tvalid || m_tready), "input ready does not track the output stage")
    `COP_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result shown straight after reset")

endmodule

bind circle_overlap_push_out_core cop_checker u_cop_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### bench/tb_circle_overlap_push_out_core.sv
// ----------------------------------------------------------------------------
// Circle overlap push-out core: testbench
// Streams body pairs through the core, with random idling on both sides but
// in the full-rate test, predicts each result with an independent model of
// the push-out arithmetic and checks every field of each transfer in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_overlap_push_out_core;
    import cop_pkg::*;

    typedef struct packed {
        logic [31:0] new_x;
        logic [31:0] new_z;
        logic        pushed;
    } push_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_addr = REG_MAX_PUSH;
    logic [30:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         m_tuser;

    push_result_t expected_q[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           pairs_sent = 0;
    int           overlaps_sent = 0;
    longint       cycles = 0;
    bit           src_idle_en = 1'b1;
    bit           sink_idle_en = 1'b1;
    logic [30:0]  max_push_reg;
    logic [16:0]  gain_reg;

    circle_overlap_push_out_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("FAIL circle_overlap_push_out_core");
            $finish;
        end
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_sqrt(input longint unsigned v);
        longint unsigned lo = 0, hi = 64'd3037000500, mid;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v) lo = mid;
            else hi = mid - 1;
        end
        return longint'(lo);
    endfunction

    function automatic push_result_t predict_push(input logic [31:0] sx, sz, ox, oz,
                                                  input logic [30:0] rs, ro);
        push_result_t r;
        longint dx, dz, sep, min_dist, overlap, push, nx, nz, g;
        longint unsigned sq;
        dx = clamp32(longint'($signed(sx)) - longint'($signed(ox)));
        dz = clamp32(longint'($signed(sz)) - longint'($signed(oz)));
        sq = longint'(dx * dx) + longint'(dz * dz);
        sep = floor_sqrt(sq);
        min_dist = longint'(rs) + longint'(ro);
        nx = $signed(sx);
        nz = $signed(sz);
        r.pushed = 1'b0;
        if (sep < min_dist) begin
            g = (gain_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_reg);
            overlap = min_dist - sep;
            if (overlap > longint'(max_push_reg)) overlap = longint'(max_push_reg);
            push = (overlap * g) >>> 16;
            r.pushed = 1'b1;
            if (sep > 66) begin
                nx = clamp32(nx + (push * dx) / sep);
                nz = clamp32(nz + (push * dz) / sep);
            end else begin
                nx = clamp32(nx + push);
            end
        end
        r.new_x = nx[31:0];
        r.new_z = nz[31:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp);
        mismatches++;
        $display("Mismatch on %s at result %0d: got %h, expected %h",
                 what, results_seen, got, exp);
    endtask

    always @(posedge aclk) begin
        push_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[31:0], 32'h0);
            end else begin
                e = expected_q.pop_front();
                if (m_tdata[31:0] !== e.new_x) report_mismatch("new_x", m_tdata[31:0], e.new_x);
                if (m_tdata[63:32] !== e.new_z) report_mismatch("new_z", m_tdata[63:32], e.new_z);
                if (m_tuser !== e.pushed) report_mismatch("pushed", 32'(m_tuser), 32'(e.pushed));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        m_tready <= sink_idle_en ? ($urandom_range(99) >= 36) : 1'b1;
    end

    task automatic send_pair(input logic [31:0] sx, sz, ox, oz, input logic [30:0] rs, ro);
        push_result_t e;
        if (src_idle_en) begin
            while ($urandom_range(99) < 36) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        e = predict_push(sx, sz, ox, oz, rs, ro);
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, ro, rs, oz, ox, sz, sx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(e);
        pairs_sent++;
        if (e.pushed) overlaps_sent++;
    endtask

    task automatic write_reg(input logic addr, input logic [30:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr == REG_MAX_PUSH) max_push_reg = value;
        else gain_reg = value[16:0];
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic random_pairs(input int n, input int spread);
        logic [31:0] sx, sz, ox, oz;
        logic [30:0] rs, ro;
        for (int i = 0; i < n; i++) begin
            sx = $urandom;
            sz = $urandom;
            if ($urandom_range(9) < 7) begin
                ox = sx + $signed($urandom_range(2 * spread) - spread);
                oz = sz + $signed($urandom_range(2 * spread) - spread);
                rs = 31'($urandom_range(spread));
                ro = 31'($urandom_range(spread));
            end else begin
                ox = $urandom;
                oz = $urandom;
                rs = 31'($urandom);
                ro = 31'($urandom);
            end
            send_pair(sx, sz, ox, oz, rs, ro);
        end
    endtask

    task automatic test_directed();
        send_pair(32'h0001_0000, 0, 0, 0, 31'h8000, 31'h8000);
        send_pair(32'h0000_8000, 0, 0, 0, 31'h8000, 31'h8000);
        send_pair(0, 32'h0000_4000, 0, 0, 31'h8000, 31'h8000);
        send_pair(5, 7, 5, 7, 31'h1_0000, 31'h1_0000);
        send_pair(40, 30, 0, 0, 31'h1_0000, 31'd0);
        send_pair(50, 50, 0, 0, 31'h1_0000, 31'd0);
        send_pair(32'h7FFF_FFF0, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_pair(32'hFFFF_0000, 32'hFFFF_0000, 0, 0, 31'd0, 31'd0);
        send_pair(32'hFFFF_F000, 32'h0000_1000, 0, 0, 31'h1, 31'h1);
        send_pair(0, 0, 0, 0, 31'd0, 31'd0);
        drain();
    endtask

    task automatic test_config_sweep();
        write_reg(REG_MAX_PUSH, 31'h7FFF_FFFF);
        write_reg(REG_SMOOTHING_GAIN, 31'h1FFFF);
        random_pairs(200, 1 << 20);
        drain();
        write_reg(REG_MAX_PUSH, 31'd0);
        write_reg(REG_SMOOTHING_GAIN, 31'd0);
        random_pairs(100, 1 << 18);
        drain();
        write_reg(REG_MAX_PUSH, 31'h0000_4000);
        write_reg(REG_SMOOTHING_GAIN, 31'h0000_8000);
        random_pairs(200, 1 << 17);
        drain();
        write_reg(REG_MAX_PUSH, 31'h7FFF_FFFF);
        write_reg(REG_SMOOTHING_GAIN, 31'h0001_0000);
        random_pairs(150, 200);
        drain();
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_MAX_PUSH, 31'($urandom));
            write_reg(REG_SMOOTHING_GAIN, 31'($urandom_range(17'h1FFFF)));
            random_pairs(120, 1 << $urandom_range(30, 6));
            drain();
        end
    endtask

    task automatic test_full_rate();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        random_pairs(150, 1 << 16);
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        drain();
    endtask

    initial begin
        max_push_reg = 31'd65536;
        gain_reg = 17'd65536;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_sweep();
        test_random_mix();
        test_full_rate();
        $display("Sent %0d body pairs, %0d overlapping, over several register settings.",
                 pairs_sent, overlaps_sent);
        $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS circle_overlap_push_out_core");
        end else begin
            $display("FAIL circle_overlap_push_out_core");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/cop_pkg.sv
design/cop_sqrt.sv
design/cop_div.sv
design/circle_overlap_push_out_core.sv
design/cop_checker.sv
bench/tb_circle_overlap_push_out_core.sv
